// ===== sv/i2c_master_bit_engine_core_assert.svh =====
// Assertion macros used by the I2C master bit engine top level.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define I2CMBE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define I2CMBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/i2cmbe_pkg.sv =====
// Types and constants of the I2C master bit engine.
package i2cmbe_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam logic [QCW-1:0] Q_DEPTH_CNT = QCW'(QDEPTH);

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_RESERVED = 3'd7;

  typedef enum logic [2:0] {
    CMD_IDLE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    IK_TICK,
    IK_CMD,
    IK_IGNORE
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       ack_flag;
    logic       sda_in;
  } q_item_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
  } pins_t;

endpackage

// ===== sv/i2cmbe_ifs.sv =====
// Channel interfaces: command/tick items, result items, configuration writes.
interface i2cmbe_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data_byte;
  logic       ack_flag;
  logic       sda_in;
  modport source (output valid, func, data_byte, ack_flag, sda_in, input ready);
  modport sink   (input valid, func, data_byte, ack_flag, sda_in, output ready);
endinterface

interface i2cmbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       rejected;
  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_seen, rejected, output ready);
endinterface

interface i2cmbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/i2cmbe_front.sv =====
// Front end: accepts items and classifies them as tick, command or ignored code.
module i2cmbe_front (
  i2cmbe_cmd_if.sink         cmd,
  input  i2cmbe_pkg::q_stat_t q_stat,
  output logic               q_push,
  output i2cmbe_pkg::q_item_t q_item
);

  assign cmd.ready = !q_stat.full;
  assign q_push    = cmd.valid && cmd.ready;

  always_comb begin
    q_item.data_byte = cmd.data_byte;
    q_item.ack_flag  = cmd.ack_flag;
    q_item.sda_in    = cmd.sda_in;
    q_item.cmd       = i2cmbe_pkg::CMD_IDLE;
    priority if (cmd.func == i2cmbe_pkg::FUNC_TICK) begin
      q_item.kind = i2cmbe_pkg::IK_TICK;
    end else if (cmd.func == i2cmbe_pkg::FUNC_RESERVED) begin
      q_item.kind = i2cmbe_pkg::IK_IGNORE;
    end else begin
      q_item.kind = i2cmbe_pkg::IK_CMD;
      q_item.cmd  = i2cmbe_pkg::cmd_t'(cmd.func);
    end
  end

endmodule

// ===== sv/i2cmbe_fifo.sv =====
// Short item queue between the front end and the bit engine.
module i2cmbe_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cmbe_pkg::q_item_t push_item,
  input  logic                pop,
  output i2cmbe_pkg::q_item_t head,
  output i2cmbe_pkg::q_stat_t stat
);

  i2cmbe_pkg::q_item_t                mem [i2cmbe_pkg::QDEPTH];
  logic [i2cmbe_pkg::QAW-1:0]         wr_ptr;
  logic [i2cmbe_pkg::QAW-1:0]         rd_ptr;
  logic [i2cmbe_pkg::QCW-1:0]         count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == i2cmbe_pkg::Q_DEPTH_CNT);

endmodule

// ===== sv/i2cmbe_back.sv =====
// Bit engine: phase timer, command sequencer, pin registers and result register.
module i2cmbe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  i2cmbe_pkg::q_item_t q_item,
  output logic                q_pop,
  i2cmbe_cfg_if.sink          cfg,
  i2cmbe_res_if.source        res
);

  i2cmbe_pkg::cmd_t  active, active_next;
  logic [1:0]        phase_step, phase_step_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [3:0]        bit_index, bit_index_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic              pending_ack, pending_ack_next;
  i2cmbe_pkg::pins_t pins, pins_next;
  logic              ack_reg, ack_reg_next;
  logic [7:0]        rx_byte, rx_byte_next;
  logic [15:0]       half_period;
  logic              done_next, rej_next, fin;
  logic              tick_wrap;
  logic              take;

  // Pin levels for a given command and phase.
  function automatic i2cmbe_pkg::pins_t apply_phase(
    input i2cmbe_pkg::cmd_t  c,
    input logic [1:0]        step,
    input logic [7:0]        sb,
    input logic              pend,
    input i2cmbe_pkg::pins_t p_in
  );
    i2cmbe_pkg::pins_t p;
    p = p_in;
    unique case (c)
      i2cmbe_pkg::CMD_START: begin
        p.drive = 1'b1;
        p.sda   = (step == 2'd0);
        p.scl   = (step < 2'd2);
      end
      i2cmbe_pkg::CMD_STOP: begin
        p.drive = 1'b1;
        p.sda   = (step != 2'd0);
        p.scl   = 1'b1;
      end
      i2cmbe_pkg::CMD_WRITE: begin
        p.drive = 1'b1;
        if (step == 2'd0) begin
          p.sda = sb[7];
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      i2cmbe_pkg::CMD_READ: begin
        if (step < 2'd2) begin
          p.drive = 1'b0;
          p.scl   = (step == 2'd0);
        end else begin
          p.drive = 1'b1;
          p.sda   = !pend;
          p.scl   = (step == 2'd2);
        end
      end
      i2cmbe_pkg::CMD_SEND_ACK: begin
        p.drive = 1'b1;
        p.sda   = !pend;
        p.scl   = (step == 2'd0);
      end
      i2cmbe_pkg::CMD_RECV_ACK: begin
        p.drive = 1'b0;
        p.scl   = (step == 2'd0);
      end
      default: p = p_in;
    endcase
    return p;
  endfunction

  assign take      = q_valid && (!res.valid || res.ready);
  assign q_pop     = take;
  assign cfg.ready = 1'b1;
  assign tick_wrap = ({1'b0, tick_count} + 17'd1) >= {1'b0, half_period};

  // Next state of the sequencer for the item at the queue head.
  always_comb begin
    active_next      = active;
    phase_step_next  = phase_step;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    pending_ack_next = pending_ack;
    pins_next        = pins;
    ack_reg_next     = ack_reg;
    rx_byte_next     = rx_byte;
    done_next        = 1'b0;
    rej_next         = 1'b0;
    fin              = 1'b0;
    unique case (q_item.kind)
      i2cmbe_pkg::IK_TICK: begin
        if (active != i2cmbe_pkg::CMD_IDLE) begin
          if (tick_wrap) begin
            tick_count_next = '0;
            unique case (active)
              i2cmbe_pkg::CMD_START: begin
                if (phase_step < 2'd2) phase_step_next = phase_step + 2'd1;
                else fin = 1'b1;
              end
              i2cmbe_pkg::CMD_STOP, i2cmbe_pkg::CMD_SEND_ACK: begin
                if (phase_step == 2'd0) phase_step_next = 2'd1;
                else fin = 1'b1;
              end
              i2cmbe_pkg::CMD_WRITE: begin
                if (phase_step == 2'd0) begin
                  phase_step_next = 2'd1;
                end else begin
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  bit_index_next  = bit_index + 4'd1;
                  if (bit_index_next >= i2cmbe_pkg::BITS_PER_BYTE) fin = 1'b1;
                  else phase_step_next = 2'd0;
                end
              end
              i2cmbe_pkg::CMD_READ: begin
                unique case (phase_step)
                  2'd0: begin
                    shift_byte_next = {shift_byte[6:0], q_item.sda_in};
                    phase_step_next = 2'd1;
                  end
                  2'd1: begin
                    bit_index_next = bit_index + 4'd1;
                    if (bit_index_next >= i2cmbe_pkg::BITS_PER_BYTE) begin
                      rx_byte_next    = shift_byte;
                      phase_step_next = 2'd2;
                    end else begin
                      phase_step_next = 2'd0;
                    end
                  end
                  2'd2:    phase_step_next = 2'd3;
                  default: fin = 1'b1;
                endcase
              end
              i2cmbe_pkg::CMD_RECV_ACK: begin
                if (phase_step == 2'd0) begin
                  ack_reg_next    = q_item.sda_in;
                  phase_step_next = 2'd1;
                end else begin
                  fin = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
            if (fin) begin
              active_next     = i2cmbe_pkg::CMD_IDLE;
              phase_step_next = '0;
              bit_index_next  = '0;
              done_next       = 1'b1;
            end else begin
              pins_next = apply_phase(active, phase_step_next, shift_byte_next,
                                      pending_ack, pins);
            end
          end else begin
            tick_count_next = tick_count + 16'd1;
          end
        end
      end
      i2cmbe_pkg::IK_CMD: begin
        if (active != i2cmbe_pkg::CMD_IDLE) begin
          rej_next = 1'b1;
        end else begin
          active_next     = q_item.cmd;
          phase_step_next = '0;
          tick_count_next = '0;
          bit_index_next  = '0;
          if (q_item.cmd == i2cmbe_pkg::CMD_WRITE) shift_byte_next = q_item.data_byte;
          if (q_item.cmd == i2cmbe_pkg::CMD_READ) begin
            shift_byte_next = '0;
            pins_next.sda   = 1'b1;
          end
          if (q_item.cmd == i2cmbe_pkg::CMD_READ || q_item.cmd == i2cmbe_pkg::CMD_SEND_ACK) begin
            pending_ack_next = q_item.ack_flag;
          end
          pins_next = apply_phase(q_item.cmd, 2'd0, shift_byte_next,
                                  pending_ack_next, pins_next);
        end
      end
      default: begin
        // reserved code: no effect, timer does not advance
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= i2cmbe_pkg::CMD_IDLE;
      phase_step  <= '0;
      tick_count  <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      pending_ack <= 1'b0;
      pins        <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
      ack_reg     <= 1'b0;
      rx_byte     <= '0;
    end else if (take) begin
      active      <= active_next;
      phase_step  <= phase_step_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      pending_ack <= pending_ack_next;
      pins        <= pins_next;
      ack_reg     <= ack_reg_next;
      rx_byte     <= rx_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cmbe_pkg::HALF_PERIOD_RST;
    end else if (cfg.valid && cfg.ready) begin
      half_period <= cfg.data;
    end
  end

  // Result register: parts the engine from the output stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.scl_level <= pins_next.scl;
      res.sda_level <= pins_next.drive ? pins_next.sda : 1'b1;
      res.sda_drive <= pins_next.drive;
      res.busy_res  <= (active_next != i2cmbe_pkg::CMD_IDLE);
      res.done_res  <= done_next;
      res.read_data <= rx_byte_next;
      res.ack_seen  <= ack_reg_next;
      res.rejected  <= rej_next;
    end
  end

endmodule

// ===== sv/i2c_master_bit_engine_core.sv =====
// I2C master bit engine top level: front end, item queue, bit engine.
// A result is valid once its item has passed the queue write and then the result register;
// it is held while the output is stalled. Throughput: one tick or command item per cycle
// while the queue has room; the engine takes one queued item a cycle unless the output stalls.
// Bus timing comes from counting tick items, half_period ticks per pin phase.
// Reset (rst, synchronous): engine idle, SCL and SDA driven high, queue empty,
// half_period back to 5.
`include "i2c_master_bit_engine_core_assert.svh"

module i2c_master_bit_engine_core (
  input logic          clk,
  input logic          rst,
  i2cmbe_cmd_if.sink   cmd,
  i2cmbe_cfg_if.sink   cfg,
  i2cmbe_res_if.source res
);

  logic                q_push;
  logic                q_pop;
  i2cmbe_pkg::q_item_t q_in;
  i2cmbe_pkg::q_item_t q_head;
  i2cmbe_pkg::q_stat_t q_stat;

  i2cmbe_front u_front (
    .cmd    (cmd),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_item (q_in)
  );

  i2cmbe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  i2cmbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!q_stat.empty),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .res     (res)
  );

  `I2CMBE_ASSERT_IMP(a_done_idle, res.valid && res.done_res, !res.busy_res, "done while busy")
  `I2CMBE_ASSERT_IMP(a_rej_busy, res.valid && res.rejected, res.busy_res, "reject while idle")
  `I2CMBE_ASSERT(a_q_bound, q_stat.count <= i2cmbe_pkg::Q_DEPTH_CNT, "queue overfilled")
  `I2CMBE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")

endmodule
